// ----- hdl/ett_pkg.sv -----
// Shared types for the totient unit: divider operand selects and control/status bundles.
`default_nettype none

package ett_pkg;

	// Operand pairs the shared divider can be started on
	typedef enum logic [1:0] {
		DIV_REST_BY_P,
		DIV_ACC_BY_P,
		DIV_ACC_BY_REST,
		DIV_QUO_BY_P      // last quotient by p, while rest takes that quotient
	} ett_div_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic         load;          // take n into rest/acc, restart trial divisor
		logic         div_start;     // launch a division
		ett_div_sel_t div_sel;       // which operands
		logic         rest_from_quo; // rest <= quotient
		logic         acc_sub_quo;   // acc <= acc - quotient
		logic         p_next;        // advance trial divisor
		logic         out_load;      // move acc into output register
	} ett_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic sq_gt_rest; // p*p > rest
		logic rest_gt1;   // rest > 1
		logic div_done;   // division result valid this cycle
		logic rem_zero;   // remainder is zero
		logic out_free;   // output register can take a new beat
	} ett_sts_t;

endpackage

`default_nettype wire

// ----- hdl/euler_totient_counter_unit.sv -----
// Top level of the Euler totient unit.
//
// Channels: slave stream s_* carries n, master stream m_* carries phi(n).
// A beat moves on a rising edge where tvalid and tready are both high.
// s_tready is high only while the unit is idle; one n is worked at a time.
// phi is found by trial division: for each candidate p with p*p <= rest,
// a restoring divider tests p; if p divides rest, it then divides the
// accumulator and strips every power of p out of rest. A rest above one
// at the end is a final prime factor. phi(0) = 0, phi(1) = 1.
// The result sits in an output register; while the receiver stalls it
// holds there and the unit waits before loading the next result, but a
// new n is taken as soon as the previous computation has been handed off.
// Reset (arst_n low) returns the controller to idle and drops m_tvalid.
`default_nettype none

module euler_totient_counter_unit
	import ett_pkg::*;
#(
	parameter int WIDTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [((WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // [WIDTH-1:0] n, rest zero
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [((WIDTH + 7) / 8) * 8 - 1:0] m_tdata   // [WIDTH-1:0] phi, rest zero
);

	localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;

	ett_cmd_t         cmd;
	ett_sts_t         sts;
	logic [WIDTH-1:0] phi;

	ett_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ett_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.n         (s_tdata[WIDTH-1:0]),
		.out_ready (m_tready),
		.sts       (sts),
		.phi       (phi),
		.out_valid (m_tvalid)
	);

	assign m_tdata = TDATA_W'(phi);

endmodule

`default_nettype wire

// ----- hdl/ett_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module ett_div
	import ett_pkg::*;
#(
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic      [WIDTH-1:0] quotient,
	output logic      [WIDTH-1:0] remainder,
	output logic                  done
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] rem_next;
	logic             qbit;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		shifted  = {rem_q, quo_q[WIDTH-1]};
		diff     = shifted - {1'b0, dvs_q};
		qbit     = ~diff[WIDTH];
		rem_next = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[WIDTH-2:0], qbit};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CNT_W'(1)) |=> done_q)
		else $error("divider missed its done pulse");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dvs_q))
		else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- hdl/ett_datapath.sv -----
// Totient datapath: rest, accumulator, trial divisor and its square, output register.
`default_nettype none

module ett_datapath
	import ett_pkg::*;
#(
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ett_cmd_t         cmd,
	input  wire logic [WIDTH-1:0] n,
	input  wire logic             out_ready,
	output ett_sts_t              sts,
	output logic      [WIDTH-1:0] phi,
	output logic                  out_valid
);

	// p never exceeds sqrt(n)+1, so its square fits in two extra bits
	localparam int SQ_W = WIDTH + 2;

	logic [WIDTH-1:0] rest_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] p_q;
	logic [SQ_W-1:0]  sq_q;
	logic [WIDTH-1:0] phi_q;
	logic             out_valid_q;

	logic [WIDTH-1:0] dividend;
	logic [WIDTH-1:0] divisor;
	logic [WIDTH-1:0] quo;
	logic [WIDTH-1:0] rem;
	logic             div_done;

	// Operand select for the shared divider
	always_comb begin
		unique case (cmd.div_sel)
			DIV_REST_BY_P: begin
				dividend = rest_q;
				divisor  = p_q;
			end
			DIV_ACC_BY_P: begin
				dividend = acc_q;
				divisor  = p_q;
			end
			DIV_ACC_BY_REST: begin
				dividend = acc_q;
				divisor  = rest_q;
			end
			DIV_QUO_BY_P: begin
				dividend = quo;
				divisor  = p_q;
			end
			default: begin
				dividend = rest_q;
				divisor  = p_q;
			end
		endcase
	end

	ett_div #(.WIDTH(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.quotient  (quo),
		.remainder (rem),
		.done      (div_done)
	);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= n;
			acc_q  <= n;
			p_q    <= WIDTH'(2);
			sq_q   <= SQ_W'(4);
		end else begin
			if (cmd.rest_from_quo)
				rest_q <= quo;
			if (cmd.acc_sub_quo)
				acc_q <= acc_q - quo;
			if (cmd.p_next) begin
				p_q  <= p_q + 1'b1;
				// (p+1)^2 = p^2 + 2p + 1
				sq_q <= sq_q + {1'b0, p_q, 1'b1};
			end
		end
	end

	// Output register, frees itself when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			phi_q <= acc_q;
	end

	assign sts.sq_gt_rest = sq_q > {2'b00, rest_q};
	assign sts.rest_gt1   = rest_q > WIDTH'(1);
	assign sts.div_done   = div_done;
	assign sts.rem_zero   = rem == '0;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign phi       = phi_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/ett_ctrl.sv -----
// Totient controller: sequences trial division over candidate factors.
`default_nettype none

module ett_ctrl
	import ett_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire ett_sts_t sts,
	output ett_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TEST,
		ST_ACC,
		ST_STRIP,
		ST_FINAL,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.div_sel = DIV_REST_BY_P;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.sq_gt_rest) begin
					// leftover rest above one is a last prime factor
					if (sts.rest_gt1) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_ACC_BY_REST;
						state_d       = ST_FINAL;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.rest_from_quo = 1'b1;
						cmd.div_start     = 1'b1;
						cmd.div_sel       = DIV_ACC_BY_P;
						state_d           = ST_ACC;
					end else begin
						cmd.p_next = 1'b1;
						state_d    = ST_CHECK;
					end
				end
			end
			ST_ACC: begin
				if (sts.div_done) begin
					cmd.acc_sub_quo = 1'b1;
					cmd.div_start   = 1'b1;
					state_d         = ST_STRIP;
				end
			end
			ST_STRIP: begin
				// divide p out of rest as often as it goes; the quotient is
				// the new rest and is divided again right away
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.rest_from_quo = 1'b1;
						cmd.div_start     = 1'b1;
						cmd.div_sel       = DIV_QUO_BY_P;
					end else begin
						cmd.p_next = 1'b1;
						state_d    = ST_CHECK;
					end
				end
			end
			ST_FINAL: begin
				if (sts.div_done) begin
					cmd.acc_sub_quo = 1'b1;
					state_d         = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
